// ===== hw/rtl/natural_cubic_spline_1d_top_defines.svh =====
// Assertion macros for the natural cubic spline block.
`ifndef NATURAL_CUBIC_SPLINE_1D_TOP_DEFINES_SVH
`define NATURAL_CUBIC_SPLINE_1D_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define NCS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define NCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ncs1d_pkg.sv =====
// Shared types, status codes and saturation helpers for the spline block.
package ncs1d_pkg;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ZERO_W = 2'd1;
    localparam logic [1:0] ST_NREADY = 2'd2;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic              start;
        logic              shf;     // 1: shift dividend by FRAC_BITS, 0: no shift
        logic signed [33:0] num;
        logic signed [33:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic signed [31:0] quo;
    } t_div_rsp;

    // magnitude plus sign to saturated 32-bit signed
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] m);
        logic signed [31:0] r;
        if (neg) begin
            r = (m >= 64'h8000_0000) ? S32_MIN : -$signed(m[31:0]);
        end else begin
            r = (m > 64'h7FFF_FFFF) ? S32_MAX : $signed(m[31:0]);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh0_7FFF_FFFF) begin
            r = S32_MAX;
        end else if (v < -36'sh0_8000_0000) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ncs1d_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ncs1d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/ncs1d_div.sv =====
// Iterative signed Q divider: (num << sh) / den, rounded half away, saturated.
module ncs1d_div
    import ncs1d_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [5:0]        r_cnt, n_cnt;
    logic [33:0]       r_rem, n_rem;
    logic [63:0]       r_dvd, n_dvd;
    logic [33:0]       r_ud, n_ud;
    logic              r_neg, n_neg;
    logic              r_zero, n_zero;
    logic signed [31:0] r_quo, n_quo;

    logic [33:0] un, ud;
    logic [34:0] rem_sh;
    logic        qbit;
    logic [63:0] qfin;

    always_comb begin
        un     = i_req.num[33] ? 34'(-i_req.num) : 34'(i_req.num);
        ud     = i_req.den[33] ? 34'(-i_req.den) : 34'(i_req.den);
        rem_sh = {r_rem, r_dvd[63]};
        qbit   = (rem_sh >= {1'b0, r_ud});
        qfin   = {r_dvd[62:0], qbit};

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_ud   = r_ud;
        n_neg  = r_neg;
        n_zero = r_zero;
        n_quo  = r_quo;

        if (r_busy) begin
            n_rem = qbit ? 34'(rem_sh - {1'b0, r_ud}) : rem_sh[33:0];
            n_dvd = qfin;
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_quo  = r_zero ? 32'sd0 : sat_mag(r_neg, qfin);
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_ud   = ud;
            n_neg  = i_req.num[33] ^ i_req.den[33];
            n_zero = (i_req.den == '0);
            n_dvd  = ({30'd0, un} << (i_req.shf ? FRAC_BITS : 0)) + {31'd0, ud[33:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_ud   <= n_ud;
        r_neg  <= n_neg;
        r_zero <= n_zero;
        r_quo  <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = r_busy;
    assign o_rsp.quo  = r_quo;
endmodule

// ===== hw/rtl/natural_cubic_spline_1d_top.sv =====
// Top level of the 1-D natural cubic spline interpolator.
//
// Input channel (i_in_valid / o_in_ready): one beat is either a knot load
// (i_mode = 0: i_knot_x, i_knot_y, i_knot_last) or a query (i_mode = 1:
// i_query_x). Knots arrive in ascending x; the beat with i_knot_last set
// starts the second-derivative solve. A load after a finished set starts a
// new set. Output channel (o_out_valid / i_out_ready): one beat per query,
// o_value (signed Q, saturated) and o_status (ok, zero-width interval,
// knots not ready). Knot loads give no output beat.
// All arithmetic goes through one shared iterative divider, one 32x32
// multiplier and a reciprocal multiply for h*h/6. A knot load is written
// to the store as it is accepted. Solve: six quotients per interior knot,
// then back substitution. Query: two quotients plus binary search.
// The block works on one beat at a time; o_in_ready is high only when idle.
// A finished result sits in the output register; the next beat is taken
// while it waits, and only a second result stalls until i_out_ready.
// Reset (i_rst_n low, synchronous) clears the knot count and the ready
// flag; queries then answer not-ready until a set is loaded.
`include "natural_cubic_spline_1d_top_defines.svh"

module natural_cubic_spline_1d_top
    import ncs1d_pkg::*;
#(
    parameter int MAX_KNOTS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic signed [31:0] i_knot_x,
    input  logic signed [31:0] i_knot_y,
    input  logic               i_knot_last,
    input  logic signed [31:0] i_query_x,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_value,
    output logic [1:0]         o_status
);
    localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int CW = $clog2(MAX_KNOTS + 1);
    localparam logic signed [35:0] ONE_Q = 36'sd1 <<< FRAC_BITS;
    localparam logic signed [35:0] TWO_Q = ONE_Q <<< 1;
    localparam logic [31:0] RECIP6 = 32'hAAAA_AAAB;  // ceil(2^34 / 6)

    localparam logic [5:0] S_IDLE   = 6'd0;
    localparam logic [5:0] S_SV_I0  = 6'd1;
    localparam logic [5:0] S_SV_I1  = 6'd2;
    localparam logic [5:0] S_SV_RD1 = 6'd3;
    localparam logic [5:0] S_SV_RD2 = 6'd4;
    localparam logic [5:0] S_SV_CAP = 6'd5;
    localparam logic [5:0] S_SV_SGS = 6'd6;
    localparam logic [5:0] S_SV_SGW = 6'd7;
    localparam logic [5:0] S_SV_P   = 6'd8;
    localparam logic [5:0] S_SV_YYS = 6'd9;
    localparam logic [5:0] S_SV_YYW = 6'd10;
    localparam logic [5:0] S_SV_Q1W = 6'd11;
    localparam logic [5:0] S_SV_Q2W = 6'd12;
    localparam logic [5:0] S_SV_Q3S = 6'd13;
    localparam logic [5:0] S_SV_Q3W = 6'd14;
    localparam logic [5:0] S_SV_M2  = 6'd15;
    localparam logic [5:0] S_SV_US  = 6'd16;
    localparam logic [5:0] S_SV_UW  = 6'd17;
    localparam logic [5:0] S_BS_RD  = 6'd18;
    localparam logic [5:0] S_BS_MUL = 6'd19;
    localparam logic [5:0] S_QS_CHK = 6'd20;
    localparam logic [5:0] S_QS_CMP = 6'd21;
    localparam logic [5:0] S_QR_LO  = 6'd22;
    localparam logic [5:0] S_QR_HI  = 6'd23;
    localparam logic [5:0] S_QH     = 6'd24;
    localparam logic [5:0] S_QA_W   = 6'd25;
    localparam logic [5:0] S_QB_W   = 6'd26;
    localparam logic [5:0] S_Q_M1   = 6'd27;
    localparam logic [5:0] S_Q_M2   = 6'd28;
    localparam logic [5:0] S_Q_M3   = 6'd29;
    localparam logic [5:0] S_Q_M4   = 6'd30;
    localparam logic [5:0] S_Q_M5   = 6'd31;
    localparam logic [5:0] S_Q_M6   = 6'd32;
    localparam logic [5:0] S_Q_M7   = 6'd33;
    localparam logic [5:0] S_Q_M8   = 6'd34;
    localparam logic [5:0] S_Q_M9   = 6'd35;
    localparam logic [5:0] S_QD_S   = 6'd36;
    localparam logic [5:0] S_Q_M10  = 6'd38;
    localparam logic [5:0] S_EMIT   = 6'd39;

    // Datapath registers. During a query xa/ya hold the low knot, xb/yb the high.
    typedef struct packed {
        logic signed [31:0] xa, xb, xc, ya, yb, yc, zl, zh, q;
        logic signed [31:0] sig, p, pyy, pu, yyi, q1, dd, t, s;
        logic signed [31:0] a, b, aa, bb, ca, cb, t1, curv, hsq, hh6, nxt;
        logic signed [32:0] h;
        logic signed [33:0] lin;
    } t_dp;

    // Rounded, saturated Q product.
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic [31:0] ma, mb;
        logic [63:0] m;
        ma = a[31] ? 32'(-a) : 32'(a);
        mb = b[31] ? 32'(-b) : 32'(b);
        m  = 64'(ma) * 64'(mb);
        m  = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return sat_mag(a[31] ^ b[31], m);
    endfunction

    logic [5:0]          r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_ready, n_ready;
    logic [AW-1:0]       r_i, n_i;
    logic [AW-1:0]       r_lo, n_lo, r_hi, n_hi, r_k, n_k;
    t_dp                 r_dp, n_dp;
    logic signed [31:0]  r_rval, n_rval;
    logic [1:0]          r_rst, n_rst;
    logic                r_ov, n_ov;
    logic signed [31:0]  r_oval, n_oval;
    logic [1:0]          r_ost, n_ost;

    t_div_req            div_req;
    t_div_rsp            div_rsp;

    logic                in_acc, out_free;
    logic [CW-1:0]       eff_cnt, cnt_m1;
    logic                xy_we, z_we;
    logic [AW-1:0]       ld_addr, zw_addr, rd_addr;
    logic [31:0]         z_wdata, u_wdata;
    logic [63:0]         xy_rd, zu_rd;
    logic [31:0]         x_rd, y_rd, z_rd, u_rd;
    logic signed [31:0]  mul_a, mul_b, mul_q, hs;
    logic signed [33:0]  d0, d1, w;
    logic signed [31:0]  bs_val;
    logic [AW:0]         span, mid;
    logic [31:0]         hh6_num;
    logic [63:0]         hh6_prod;

    // knot abscissa and ordinate share one word
    ncs1d_ram #(.WIDTH(64), .DEPTH(MAX_KNOTS)) u_xy_ram (
        .i_clk(i_clk), .i_we(xy_we), .i_waddr(ld_addr), .i_wdata({i_knot_x, i_knot_y}),
        .i_raddr(rd_addr), .o_rdata(xy_rd));
    // second derivative and sweep scratch share one word
    ncs1d_ram #(.WIDTH(64), .DEPTH(MAX_KNOTS)) u_zu_ram (
        .i_clk(i_clk), .i_we(z_we), .i_waddr(zw_addr), .i_wdata({z_wdata, u_wdata}),
        .i_raddr(rd_addr), .o_rdata(zu_rd));

    assign x_rd = xy_rd[63:32];
    assign y_rd = xy_rd[31:0];
    assign z_rd = zu_rd[63:32];
    assign u_rd = zu_rd[31:0];

    ncs1d_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_ov || i_out_ready;
    assign eff_cnt    = r_ready ? '0 : r_cnt;
    assign cnt_m1     = r_cnt - CW'(1);
    assign ld_addr    = eff_cnt[AW-1:0];
    assign xy_we      = in_acc && !i_mode && (eff_cnt < CW'(MAX_KNOTS));

    assign d0   = 34'(r_dp.xb) - 34'(r_dp.xa);
    assign d1   = 34'(r_dp.xc) - 34'(r_dp.xb);
    assign w    = 34'(r_dp.xc) - 34'(r_dp.xa);
    assign hs   = sat36(36'(r_dp.h));
    assign span = {1'b0, r_hi} - {1'b0, r_lo};
    assign mid  = ({1'b0, r_hi} + {1'b0, r_lo}) >> 1;

    // h*h/6 rounded: hsq is never negative, (hsq + 3) / 6 by reciprocal
    assign hh6_num  = $unsigned(r_dp.hsq) + 32'd3;
    assign hh6_prod = {32'd0, hh6_num} * {32'd0, RECIP6};

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SV_P:   begin mul_a = r_dp.sig;      mul_b = r_dp.pyy; end
            S_SV_M2:  begin mul_a = r_dp.sig;      mul_b = r_dp.pu;  end
            S_BS_MUL: begin mul_a = $signed(z_rd); mul_b = r_dp.nxt; end
            S_Q_M1:   begin mul_a = r_dp.a;        mul_b = r_dp.ya;  end
            S_Q_M2:   begin mul_a = r_dp.b;        mul_b = r_dp.yb;  end
            S_Q_M3:   begin mul_a = r_dp.a;        mul_b = r_dp.a;   end
            S_Q_M4:   begin mul_a = r_dp.aa;       mul_b = r_dp.a;   end
            S_Q_M5:   begin mul_a = r_dp.b;        mul_b = r_dp.b;   end
            S_Q_M6:   begin mul_a = r_dp.bb;       mul_b = r_dp.b;   end
            S_Q_M7:   begin mul_a = r_dp.ca;       mul_b = r_dp.zl;  end
            S_Q_M8:   begin mul_a = r_dp.cb;       mul_b = r_dp.zh;  end
            S_Q_M9:   begin mul_a = hs;            mul_b = hs;       end
            S_Q_M10:  begin mul_a = r_dp.curv;     mul_b = r_dp.hh6; end
            default:  begin mul_a = '0;            mul_b = '0;       end
        endcase
    end
    assign mul_q  = qmul(mul_a, mul_b);
    assign bs_val = sat36(36'(mul_q) + 36'($signed(u_rd)));

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ready = r_ready;
        n_i     = r_i;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_k     = r_k;
        n_dp    = r_dp;
        n_rval  = r_rval;
        n_rst   = r_rst;
        n_ov    = r_ov && !i_out_ready;
        n_oval  = r_oval;
        n_ost   = r_ost;
        div_req = '0;
        div_req.shf = 1'b1;
        z_we    = 1'b0;
        zw_addr = r_i;
        z_wdata = '0;
        u_wdata = '0;
        rd_addr = r_i;

        case (r_state)
            S_IDLE: begin
                if (in_acc && !i_mode) begin
                    n_ready = 1'b0;
                    n_cnt   = xy_we ? eff_cnt + CW'(1) : eff_cnt;
                    if (i_knot_last) begin
                        n_state = S_SV_I0;
                    end
                end else if (in_acc) begin
                    if (!r_ready) begin
                        n_rval  = '0;
                        n_rst   = ST_NREADY;
                        n_state = S_EMIT;
                    end else begin
                        n_dp.q  = i_query_x;
                        n_lo    = '0;
                        n_hi    = cnt_m1[AW-1:0];
                        n_state = S_QS_CHK;
                    end
                end
            end
            // ---- solve: end conditions ----
            S_SV_I0: begin
                z_we     = 1'b1;
                zw_addr  = '0;
                n_dp.pyy = '0;
                n_dp.pu  = '0;
                n_state  = S_SV_I1;
            end
            S_SV_I1: begin
                z_we    = 1'b1;
                zw_addr = cnt_m1[AW-1:0];
                rd_addr = '0;
                n_dp.nxt = '0;
                if (r_cnt >= CW'(3)) begin
                    n_state = S_SV_RD1;
                end else if (r_cnt == CW'(2)) begin
                    n_i     = '0;
                    n_state = S_BS_RD;
                end else begin
                    n_ready = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SV_RD1: begin
                n_dp.xa = $signed(x_rd);
                n_dp.ya = $signed(y_rd);
                rd_addr = AW'(1);
                n_state = S_SV_RD2;
            end
            S_SV_RD2: begin
                n_dp.xb = $signed(x_rd);
                n_dp.yb = $signed(y_rd);
                rd_addr = AW'(2);
                n_i     = AW'(1);
                n_state = S_SV_CAP;
            end
            // ---- forward sweep, one interior knot per pass ----
            S_SV_CAP: begin
                n_dp.xc = $signed(x_rd);
                n_dp.yc = $signed(y_rd);
                n_state = S_SV_SGS;
            end
            S_SV_SGS: begin
                div_req.start = 1'b1;
                div_req.num   = d0;
                div_req.den   = w;
                n_state       = S_SV_SGW;
            end
            S_SV_SGW: begin
                if (div_rsp.done) begin
                    n_dp.sig = div_rsp.quo;
                    n_state  = S_SV_P;
                end
            end
            S_SV_P: begin
                n_dp.p  = sat36(36'(mul_q) + TWO_Q);
                n_state = S_SV_YYS;
            end
            S_SV_YYS: begin
                div_req.start = 1'b1;
                div_req.num   = 34'(36'(r_dp.sig) - ONE_Q);
                div_req.den   = 34'(r_dp.p);
                n_state       = S_SV_YYW;
            end
            S_SV_YYW: begin
                if (div_rsp.done) begin
                    n_dp.yyi      = div_rsp.quo;
                    div_req.start = 1'b1;
                    div_req.num   = 34'(r_dp.yc) - 34'(r_dp.yb);
                    div_req.den   = d1;
                    n_state       = S_SV_Q1W;
                end
            end
            S_SV_Q1W: begin
                if (div_rsp.done) begin
                    n_dp.q1       = div_rsp.quo;
                    div_req.start = 1'b1;
                    div_req.num   = 34'(r_dp.yb) - 34'(r_dp.ya);
                    div_req.den   = d0;
                    n_state       = S_SV_Q2W;
                end
            end
            S_SV_Q2W: begin
                if (div_rsp.done) begin
                    n_dp.dd = sat36(36'(r_dp.q1) - 36'(div_rsp.quo));
                    n_state = S_SV_Q3S;
                end
            end
            S_SV_Q3S: begin
                div_req.start = 1'b1;
                div_req.num   = 34'(r_dp.dd);
                div_req.den   = w;
                n_state       = S_SV_Q3W;
            end
            S_SV_Q3W: begin
                if (div_rsp.done) begin
                    // times six as 4x + 2x
                    n_dp.t  = sat36((36'(div_rsp.quo) <<< 2) + (36'(div_rsp.quo) <<< 1));
                    n_state = S_SV_M2;
                end
            end
            S_SV_M2: begin
                n_dp.s  = sat36(36'(r_dp.t) - 36'(mul_q));
                n_state = S_SV_US;
            end
            S_SV_US: begin
                div_req.start = 1'b1;
                div_req.num   = 34'(r_dp.s);
                div_req.den   = 34'(r_dp.p);
                n_state       = S_SV_UW;
            end
            S_SV_UW: begin
                if (div_rsp.done) begin
                    z_we     = 1'b1;
                    z_wdata  = r_dp.yyi;
                    u_wdata  = div_rsp.quo;
                    n_dp.pyy = r_dp.yyi;
                    n_dp.pu  = div_rsp.quo;
                    n_dp.xa  = r_dp.xb;
                    n_dp.xb  = r_dp.xc;
                    n_dp.ya  = r_dp.yb;
                    n_dp.yb  = r_dp.yc;
                    rd_addr  = r_i + AW'(2);
                    if ((CW + 1)'(r_i) + (CW + 1)'(2) < (CW + 1)'(r_cnt)) begin
                        n_i     = r_i + AW'(1);
                        n_state = S_SV_CAP;
                    end else begin
                        n_i      = r_i - AW'(1) + AW'(1);
                        n_dp.nxt = '0;
                        n_state  = S_BS_RD;
                    end
                end
            end
            // ---- back substitution, i = n-2 down to 0 ----
            S_BS_RD: begin
                rd_addr = r_i;
                n_state = S_BS_MUL;
            end
            S_BS_MUL: begin
                z_we     = 1'b1;
                z_wdata  = bs_val;
                u_wdata  = u_rd;   // scratch word kept as read
                n_dp.nxt = bs_val;
                if (r_i == '0) begin
                    n_ready = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_i     = r_i - AW'(1);
                    n_state = S_BS_RD;
                end
            end
            // ---- query: bracket search ----
            S_QS_CHK: begin
                if (span > (AW + 1)'(1)) begin
                    n_k     = mid[AW-1:0];
                    rd_addr = mid[AW-1:0];
                    n_state = S_QS_CMP;
                end else begin
                    rd_addr = r_lo;
                    n_state = S_QR_LO;
                end
            end
            S_QS_CMP: begin
                if ($signed(x_rd) > r_dp.q) begin
                    n_hi = r_k;
                end else begin
                    n_lo = r_k;
                end
                n_state = S_QS_CHK;
            end
            S_QR_LO: begin
                n_dp.xa = $signed(x_rd);
                n_dp.ya = $signed(y_rd);
                n_dp.zl = $signed(z_rd);
                rd_addr = r_hi;
                n_state = S_QR_HI;
            end
            S_QR_HI: begin
                n_dp.xb = $signed(x_rd);
                n_dp.yb = $signed(y_rd);
                n_dp.zh = $signed(z_rd);
                n_dp.h  = 33'($signed(x_rd)) - 33'(r_dp.xa);
                n_state = S_QH;
            end
            S_QH: begin
                if (r_dp.h == '0) begin
                    n_rval  = '0;
                    n_rst   = ST_ZERO_W;
                    n_state = S_EMIT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = 34'(r_dp.xb) - 34'(r_dp.q);
                    div_req.den   = 34'(r_dp.h);
                    n_state       = S_QA_W;
                end
            end
            S_QA_W: begin
                if (div_rsp.done) begin
                    n_dp.a        = div_rsp.quo;
                    div_req.start = 1'b1;
                    div_req.num   = 34'(r_dp.q) - 34'(r_dp.xa);
                    div_req.den   = 34'(r_dp.h);
                    n_state       = S_QB_W;
                end
            end
            S_QB_W: begin
                if (div_rsp.done) begin
                    n_dp.b  = div_rsp.quo;
                    n_state = S_Q_M1;
                end
            end
            S_Q_M1: begin
                n_dp.t1 = mul_q;
                n_state = S_Q_M2;
            end
            S_Q_M2: begin
                n_dp.lin = 34'(36'(r_dp.t1) + 36'(mul_q));
                n_state  = S_Q_M3;
            end
            S_Q_M3: begin
                n_dp.aa = mul_q;
                n_state = S_Q_M4;
            end
            S_Q_M4: begin
                n_dp.ca = sat36(36'(mul_q) - 36'(r_dp.a));
                n_state = S_Q_M5;
            end
            S_Q_M5: begin
                n_dp.bb = mul_q;
                n_state = S_Q_M6;
            end
            S_Q_M6: begin
                n_dp.cb = sat36(36'(mul_q) - 36'(r_dp.b));
                n_state = S_Q_M7;
            end
            S_Q_M7: begin
                n_dp.ca = mul_q;  // low-end curvature term
                n_state = S_Q_M8;
            end
            S_Q_M8: begin
                n_dp.curv = sat36(36'(r_dp.ca) + 36'(mul_q));
                n_state   = S_Q_M9;
            end
            S_Q_M9: begin
                n_dp.hsq = mul_q;
                n_state  = S_QD_S;
            end
            S_QD_S: begin
                n_dp.hh6 = $signed({2'b00, hh6_prod[63:34]});
                n_state  = S_Q_M10;
            end
            S_Q_M10: begin
                n_rval  = sat36(36'(r_dp.lin) + 36'(mul_q));
                n_rst   = ST_OK;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_oval  = r_rval;
                    n_ost   = r_rst;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ready <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ready <= n_ready;
            r_ov    <= n_ov;
        end
        r_i    <= n_i;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_k    <= n_k;
        r_dp   <= n_dp;
        r_rval <= n_rval;
        r_rst  <= n_rst;
        r_oval <= n_oval;
        r_ost  <= n_ost;
    end

    assign o_out_valid = r_ov;
    assign o_value     = r_oval;
    assign o_status    = r_ost;

    `NCS_ASSERT_IMPL(a_cnt_bound, 1'b1, r_cnt <= CW'(MAX_KNOTS), "knot count above store depth")
    `NCS_ASSERT_IMPL(a_idle_div, r_state == S_IDLE, !div_rsp.busy, "divider busy while idle")
    `NCS_ASSERT_IMPL(a_search_order, r_state == S_QS_CMP, r_lo < r_hi, "search bounds crossed")
    `NCS_ASSERT_NEXT(a_emit_load, (r_state == S_EMIT) && out_free, o_out_valid,
        "result not loaded on emit")
endmodule
